/* hdl/btmx_pkg.sv */
// Shared types and constants for the binary trie max-xor block.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none

package btmx_pkg;

   localparam int KEY_BITS      = 31;
   localparam int NODES         = 65536;
   localparam int COUNT_BITS    = 20;

   localparam int NODE_BITS     = $clog2(NODES);
   localparam int NFREE_BITS    = NODE_BITS + 1;
   localparam int LVL_BITS      = $clog2(KEY_BITS);
   localparam int NEED_BITS     = $clog2(KEY_BITS + 1);

   localparam int VALUE_BITS    = 31;
   localparam int ANSWER_BITS   = 31;
   localparam int REQ_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((ANSWER_BITS + 7) / 8) * 8;
   localparam int MODE_BITS     = 2;
   localparam int STATUS_BITS   = 2;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_QUERY  = 2'd2
   } mode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_ABSENT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_PREP,
      S_UPDATE,
      S_FINISH
   } state_type;

   // One child slot. The count of a node lives in its parent's slot.
   typedef struct packed {
      logic [COUNT_BITS-1:0] cnt;
      logic [NODE_BITS-1:0]  lnk;
   } slot_type;

   typedef slot_type [1:0] node_word_type;

   localparam int WORD_BITS = $bits(node_word_type);

   typedef struct packed {
      logic       load;
      logic       restart;
      logic       step;
      logic       update;
      logic       finish;
      status_type fin_status;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     last;
      logic     link_empty;
      logic     count_full;
      logic     path_absent;
      logic     query_dead;
      logic     pool_short;
   } dp_stat_type;

endpackage

`default_nettype wire

/* hdl/binary_trie_max_xor.sv */
// A query walks the trie once; an insert or a delete checks its path in one walk and
// updates it in a second. Each walk cycle reads one node word and takes one key bit, and
// a walk may end early. Items are taken one at a time; the next item is taken the cycle
// after the result is stored, while that result waits for its transfer.
// Reset clears the root word, the free-node mark and all control; nodes are written at
// allocation before they are read, so the node memory needs no clearing pass.
`default_nettype none

module binary_trie_max_xor (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [30:0] value
   input  wire logic [btmx_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // [1:0] mode
   input  wire logic [btmx_pkg::MODE_BITS-1:0]      req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [30:0] answer
   output logic      [btmx_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // [1:0] status
   output logic      [btmx_pkg::STATUS_BITS-1:0]    rsp_tuser
);
   import btmx_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   btmx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   btmx_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

/* hdl/btmx_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module btmx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/btmx_ctrl.sv */
// Sequencer for the trie walks: check pass, pool check, update pass, result hand-off.
// Depends on btmx_pkg.
`default_nettype none

module btmx_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [btmx_pkg::MODE_BITS-1:0]   req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output btmx_pkg::dp_cmd_type                  cmd,
   input  wire btmx_pkg::dp_stat_type            stat
);
   import btmx_pkg::*;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.fin_status = status_ff;
      req_tready   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load  = 1'b1;
               status_in = STAT_OK;
               if (req_tuser inside {MODE_INSERT, MODE_DELETE, MODE_QUERY}) begin
                  state_in = S_WALK;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_WALK: begin
            cmd.step = 1'b1;
            case (stat.mode)
               MODE_INSERT: begin
                  if (stat.link_empty) begin
                     state_in = S_PREP;
                  end else if (stat.count_full) begin
                     status_in = STAT_FULL;
                     state_in  = S_FINISH;
                  end else if (stat.last) begin
                     state_in = S_PREP;
                  end
               end
               MODE_DELETE: begin
                  if (stat.path_absent) begin
                     status_in = STAT_ABSENT;
                     state_in  = S_FINISH;
                  end else if (stat.last) begin
                     state_in = S_PREP;
                  end
               end
               MODE_QUERY: begin
                  if (stat.query_dead || stat.last) begin
                     state_in = S_FINISH;
                  end
               end
               default: state_in = S_FINISH;
            endcase
         end

         S_PREP: begin
            cmd.restart = 1'b1;
            if (stat.mode == MODE_INSERT && stat.pool_short) begin
               status_in = STAT_FULL;
               state_in  = S_FINISH;
            end else begin
               state_in = S_UPDATE;
            end
         end

         S_UPDATE: begin
            cmd.step   = 1'b1;
            cmd.update = 1'b1;
            if (stat.last) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            // Wait for the output register to drain before overwriting it.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

/* hdl/btmx_dpath.sv */
// Trie datapath: node memory, root word, walk registers, free-node counter, result.
// Depends on btmx_pkg and btmx_ram.
`default_nettype none

module btmx_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire btmx_pkg::dp_cmd_type                cmd,
   output btmx_pkg::dp_stat_type                    stat,
   input  wire logic [btmx_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  wire logic [btmx_pkg::MODE_BITS-1:0]      req_tuser,
   output logic      [btmx_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic      [btmx_pkg::STATUS_BITS-1:0]    rsp_tuser
);
   import btmx_pkg::*;

   mode_type              mode_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [NODE_BITS-1:0]  p_ff;
   logic [LVL_BITS-1:0]   lvl_ff;
   logic                  fresh_ff;
   logic [KEY_BITS-1:0]   x_ff;
   logic [NEED_BITS-1:0]  needed_ff;
   logic [NFREE_BITS-1:0] nf_ff;
   node_word_type         root_ff;
   logic [ANSWER_BITS-1:0] answer_ff;
   status_type            status_ff;

   logic [WORD_BITS-1:0]  rd_data;
   node_word_type         cur_word;
   node_word_type         upd_word;
   slot_type              same;
   slot_type              opp;
   logic                  side;
   logic                  same_present;
   logic                  opp_present;
   logic                  alloc;
   logic                  is_insert;
   logic [NODE_BITS-1:0]  new_node;
   logic [NODE_BITS-1:0]  p_next;
   logic                  wr_en;
   logic [KEY_BITS-1:0]   best;

   // Nodes are read only after their allocation wrote them, so the memory needs
   // no clearing. The root never lives in the memory.
   btmx_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NODES)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (p_ff),
      .wr_data (upd_word),
      .rd_addr (p_next),
      .rd_data (rd_data)
   );

   always_comb begin
      side      = key_ff[lvl_ff];
      is_insert = (mode_ff == MODE_INSERT);
      if (p_ff == '0) begin
         cur_word = root_ff;
      end else if (fresh_ff) begin
         cur_word = '0;
      end else begin
         cur_word = node_word_type'(rd_data);
      end
      same         = cur_word[side];
      opp          = cur_word[~side];
      same_present = (same.lnk != '0) && (same.cnt != '0);
      opp_present  = (opp.lnk != '0) && (opp.cnt != '0);
      alloc        = (same.lnk == '0);
      new_node     = nf_ff[NODE_BITS-1:0];

      upd_word = cur_word;
      if (!is_insert) begin
         upd_word[side].cnt = same.cnt - 1'b1;
      end else if (alloc) begin
         upd_word[side].cnt = COUNT_BITS'(1);
         upd_word[side].lnk = new_node;
      end else begin
         upd_word[side].cnt = same.cnt + 1'b1;
      end

      p_next = p_ff;
      if (cmd.step) begin
         if (mode_ff == MODE_QUERY && opp_present) begin
            p_next = opp.lnk;
         end else if (cmd.update && is_insert && alloc) begin
            p_next = new_node;
         end else begin
            p_next = same.lnk;
         end
      end

      wr_en = cmd.step && cmd.update && (p_ff != '0);
      best  = (x_ff > key_ff) ? x_ff : key_ff;

      stat.mode        = mode_ff;
      stat.last        = (lvl_ff == '0);
      stat.link_empty  = alloc;
      stat.count_full  = (same.cnt == '1);
      stat.path_absent = !same_present;
      stat.query_dead  = !opp_present && !same_present;
      stat.pool_short  = ((NFREE_BITS+1)'(nf_ff) + (NFREE_BITS+1)'(needed_ff))
                         > (NFREE_BITS+1)'(NODES);
   end

   // Trie state that the reset defines: the root word and the free-node mark.
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
         nf_ff   <= NFREE_BITS'(1);
      end else if (cmd.step && cmd.update) begin
         if (p_ff == '0) begin
            root_ff <= upd_word;
         end
         if (is_insert && alloc) begin
            nf_ff <= nf_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff     <= '0;
         lvl_ff   <= LVL_BITS'(KEY_BITS - 1);
         fresh_ff <= 1'b0;
      end else if (cmd.load || cmd.restart) begin
         p_ff     <= '0;
         lvl_ff   <= LVL_BITS'(KEY_BITS - 1);
         fresh_ff <= 1'b0;
      end else if (cmd.step) begin
         p_ff   <= p_next;
         lvl_ff <= lvl_ff - 1'b1;
         if (cmd.update && is_insert && alloc) begin
            fresh_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= mode_type'(req_tuser);
         key_ff    <= req_tdata[KEY_BITS-1:0];
         x_ff      <= '0;
         needed_ff <= '0;
      end else if (cmd.step && !cmd.update) begin
         if (mode_ff == MODE_QUERY) begin
            if (opp_present) begin
               x_ff[lvl_ff] <= 1'b1;
            end else if (!same_present) begin
               // No partner at all: the answer falls back to the key itself.
               x_ff <= '0;
            end
         end
         if (is_insert && alloc) begin
            needed_ff <= NEED_BITS'(lvl_ff) + 1'b1;
         end
      end
      if (cmd.finish) begin
         answer_ff <= (mode_ff == MODE_QUERY) ? ANSWER_BITS'(best) : '0;
         status_ff <= cmd.fin_status;
      end
   end

   assign rsp_tdata = RSP_DATA_BITS'(answer_ff);
   assign rsp_tuser = status_ff;

endmodule

`default_nettype wire

/* hdl/btmx_checker.sv */
// Port-level checks for binary_trie_max_xor, attached by the bind at the end of this file.
// Depends on btmx_pkg.
`default_nettype none

module btmx_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [btmx_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input wire logic [btmx_pkg::STATUS_BITS-1:0]    rsp_tuser
);
   import btmx_pkg::*;

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before its transfer");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Only inserts and deletes can fail, and they always answer zero.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STAT_OK) |-> (rsp_tdata == '0))
      else $error("failed operation carries a nonzero answer");

endmodule

bind binary_trie_max_xor btmx_checker u_btmx_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

/* tb/binary_trie_max_xor_tb.sv */
// Self-checking testbench for binary_trie_max_xor: insert, delete, query and unused-mode
// transfers go in on the request stream, and each response is compared with a trie predictor
// held here or with a probe row's typed result. Depends on btmx_pkg and binary_trie_max_xor only.
`timescale 1ns / 1ps

module binary_trie_max_xor_tb;
   import btmx_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 3;
   localparam int PROBE_ROWS   = 25;
   localparam int RANDOM_ITEMS = 850;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_PCT     = 27;
   localparam longint RUN_LIMIT_NS = 30_000_000;

   // Mode code that the block takes but does nothing with.
   localparam logic [MODE_BITS-1:0] MODE_IGNORED = 2'd3;

   typedef struct {
      logic [ANSWER_BITS-1:0] answer;
      status_type             status;
      int unsigned            item;
   } outcome_type;

   typedef struct {
      logic [MODE_BITS-1:0]   mode;
      logic [KEY_BITS-1:0]    key;
      bit                     typed;
      logic [ANSWER_BITS-1:0] answer;
      status_type             status;
   } probe_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [MODE_BITS-1:0]     req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0]   rsp_tuser;

   // Predicted trie: child links, per-node counts and the next never-used node.
   bit [NODE_BITS-1:0]  trie_link [2*NODES];
   bit [COUNT_BITS-1:0] trie_count [NODES];
   int unsigned         trie_next_free = 1;

   outcome_type         pending_outcomes [$];
   logic [KEY_BITS-1:0] live_keys [$];
   logic [KEY_BITS-1:0] cluster_base [4];

   bit          sender_calm = 1'b0;
   int unsigned items_sent  = 0;
   int unsigned mismatches  = 0;
   int unsigned n_stored    = 0;
   int unsigned n_full      = 0;
   int unsigned n_removed   = 0;
   int unsigned n_absent    = 0;
   int unsigned n_queries   = 0;
   int unsigned n_ignored   = 0;

   probe_row_type probe_rows [PROBE_ROWS] = '{
      '{MODE_QUERY,   31'h0000_0000, 1'b1, 31'h0000_0000, STAT_OK},
      '{MODE_QUERY,   31'h7FFF_FFFF, 1'b1, 31'h7FFF_FFFF, STAT_OK},
      '{MODE_DELETE,  31'h0000_0000, 1'b1, 31'h0000_0000, STAT_ABSENT},
      '{MODE_DELETE,  31'h7FFF_FFFF, 1'b1, 31'h0000_0000, STAT_ABSENT},
      '{MODE_IGNORED, 31'h7FFF_FFFF, 1'b1, 31'h0000_0000, STAT_OK},
      '{MODE_INSERT,  31'h0000_0000, 1'b1, 31'h0000_0000, STAT_OK},
      '{MODE_QUERY,   31'h7FFF_FFFF, 1'b1, 31'h7FFF_FFFF, STAT_OK},
      '{MODE_QUERY,   31'h0000_0000, 1'b1, 31'h0000_0000, STAT_OK},
      '{MODE_INSERT,  31'h7FFF_FFFF, 1'b1, 31'h0000_0000, STAT_OK},
      '{MODE_QUERY,   31'h0000_0000, 1'b1, 31'h7FFF_FFFF, STAT_OK},
      '{MODE_QUERY,   31'h7FFF_FFFF, 1'b1, 31'h7FFF_FFFF, STAT_OK},
      '{MODE_QUERY,   31'h5555_5555, 1'b0, 31'h0000_0000, STAT_OK},
      '{MODE_INSERT,  31'h0000_0000, 1'b1, 31'h0000_0000, STAT_OK},
      '{MODE_DELETE,  31'h0000_0000, 1'b1, 31'h0000_0000, STAT_OK},
      '{MODE_DELETE,  31'h0000_0000, 1'b1, 31'h0000_0000, STAT_OK},
      '{MODE_DELETE,  31'h0000_0000, 1'b1, 31'h0000_0000, STAT_ABSENT},
      '{MODE_QUERY,   31'h0000_0000, 1'b1, 31'h7FFF_FFFF, STAT_OK},
      '{MODE_DELETE,  31'h7FFF_FFFF, 1'b1, 31'h0000_0000, STAT_OK},
      '{MODE_QUERY,   31'h1234_5678, 1'b1, 31'h1234_5678, STAT_OK},
      '{MODE_INSERT,  31'h0000_0001, 1'b1, 31'h0000_0000, STAT_OK},
      '{MODE_QUERY,   31'h0000_0001, 1'b0, 31'h0000_0000, STAT_OK},
      '{MODE_INSERT,  31'h4000_0000, 1'b1, 31'h0000_0000, STAT_OK},
      '{MODE_QUERY,   31'h3FFF_FFFF, 1'b0, 31'h0000_0000, STAT_OK},
      '{MODE_DELETE,  31'h4000_0001, 1'b1, 31'h0000_0000, STAT_ABSENT},
      '{MODE_IGNORED, 31'h0000_0000, 1'b1, 31'h0000_0000, STAT_OK}
   };

   binary_trie_max_xor i_dut (.*);

   always #(HALF_PERIOD) clock = ~clock;

   // A node with a zero count is treated as absent even though its link is kept.
   function automatic bit node_live(int unsigned l);
      return l != 0 && trie_count[l] != 0;
   endfunction

   function automatic status_type trie_insert(logic [KEY_BITS-1:0] key);
      int unsigned p = 0;
      int unsigned needed = 0;
      int unsigned l;
      bit fresh = 1'b0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
         if (fresh) begin
            needed++;
         end else begin
            l = trie_link[2*p + key[i]];
            if (l == 0) begin
               fresh = 1'b1;
               needed++;
            end else if (trie_count[l] == {COUNT_BITS{1'b1}}) begin
               return STAT_FULL;
            end else begin
               p = l;
            end
         end
      end
      if (trie_next_free + needed > NODES)
         return STAT_FULL;
      p = 0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
         l = trie_link[2*p + key[i]];
         if (l == 0) begin
            l = trie_next_free;
            trie_next_free++;
            trie_link[2*l]     = '0;
            trie_link[2*l + 1] = '0;
            trie_count[l]      = '0;
            trie_link[2*p + key[i]] = l[NODE_BITS-1:0];
         end
         trie_count[l]++;
         p = l;
      end
      return STAT_OK;
   endfunction

   function automatic status_type trie_delete(logic [KEY_BITS-1:0] key);
      int unsigned p = 0;
      int unsigned l;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
         l = trie_link[2*p + key[i]];
         if (!node_live(l))
            return STAT_ABSENT;
         p = l;
      end
      p = 0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
         l = trie_link[2*p + key[i]];
         trie_count[l]--;
         p = l;
      end
      return STAT_OK;
   endfunction

   // Greedy walk toward the opposite bit; zero always counts as a partner.
   function automatic logic [ANSWER_BITS-1:0] trie_best_xor(logic [KEY_BITS-1:0] key);
      int unsigned p = 0;
      int unsigned opp;
      int unsigned same;
      logic [KEY_BITS-1:0] x = '0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
         opp  = trie_link[2*p + (key[i] ^ 1'b1)];
         same = trie_link[2*p + key[i]];
         if (node_live(opp)) begin
            x[i] = 1'b1;
            p = opp;
         end else if (node_live(same)) begin
            p = same;
         end else begin
            x = '0;
            break;
         end
      end
      return (x > key) ? x : key;
   endfunction

   function automatic outcome_type trie_apply(logic [MODE_BITS-1:0] mode,
                                              logic [KEY_BITS-1:0] key);
      outcome_type o;
      o.answer = '0;
      o.status = STAT_OK;
      o.item   = 0;
      case (mode)
         MODE_INSERT: o.status = trie_insert(key);
         MODE_DELETE: o.status = trie_delete(key);
         MODE_QUERY:  o.answer = trie_best_xor(key);
         default: ;
      endcase
      return o;
   endfunction

   function automatic logic [KEY_BITS-1:0] fresh_key();
      int unsigned r = $urandom_range(99);
      logic [KEY_BITS-1:0] k = KEY_BITS'($urandom);
      if (r < 30)
         k = cluster_base[$urandom_range(3)] ^ KEY_BITS'($urandom_range(255));
      else if (r < 40)
         k = KEY_BITS'(1) << $urandom_range(KEY_BITS - 1);
      else if (r < 48)
         k = ~(KEY_BITS'(1) << $urandom_range(KEY_BITS - 1));
      else if (r < 52)
         k = $urandom_range(1) ? '0 : '1;
      return k;
   endfunction

   task automatic report_mismatch(string what, int unsigned item, logic [63:0] got,
                                  logic [63:0] want);
      $display("[%0t] item %0d: %s got %h, expected %h", $realtime, item, what, got, want);
      mismatches++;
   endtask

   // Offers one transfer and, once it is taken, predicts its response.
   task automatic send_op(logic [MODE_BITS-1:0] mode, logic [KEY_BITS-1:0] key, bit typed,
                          logic [ANSWER_BITS-1:0] typed_answer, status_type typed_status);
      outcome_type o;
      if (!sender_calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_DATA_BITS'(key);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      o = trie_apply(mode, key);
      case (mode)
         MODE_INSERT: begin
            if (o.status == STAT_OK) begin
               n_stored++;
               live_keys = {live_keys, key};
            end else begin
               n_full++;
            end
         end
         MODE_DELETE: begin
            if (o.status == STAT_OK) begin
               n_removed++;
               for (int j = 0; j < live_keys.size(); j++)
                  if (live_keys[j] == key) begin
                     live_keys.delete(j);
                     break;
                  end
            end else begin
               n_absent++;
            end
         end
         MODE_QUERY: n_queries++;
         default:    n_ignored++;
      endcase
      o.item = items_sent;
      items_sent++;
      if (typed) begin
         o.answer = typed_answer;
         o.status = typed_status;
      end
      pending_outcomes = {pending_outcomes, o};
   endtask

   always @(posedge clock) begin : rsp_check
      outcome_type o;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response with nothing pending", items_sent, 64'(rsp_tdata),
                            64'd0);
         end else begin
            o = pending_outcomes.pop_front();
            if (rsp_tdata !== RSP_DATA_BITS'(o.answer))
               report_mismatch("answer", o.item, 64'(rsp_tdata), 64'(o.answer));
            if (rsp_tuser !== o.status)
               report_mismatch("status", o.item, 64'(rsp_tuser), 64'(o.status));
         end
      end
   end

   // Response side: random stalls, a calm window, and long hold-offs that back up the block.
   initial begin : receiver
      int unsigned hold_left;
      int unsigned taken;
      int unsigned next_hold;
      hold_left = 0;
      taken     = 0;
      next_hold = 40;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready)
            taken++;
         if (hold_left == 0 && taken >= next_hold) begin
            hold_left = HOLD_CYCLES;
            next_hold = next_hold + 700;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (taken >= 300 && taken < 450) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin : stimulus
      int unsigned n;
      int unsigned roll;
      bit have_live;
      logic [KEY_BITS-1:0] pick;

      for (int b = 0; b < 4; b++)
         cluster_base[b] = KEY_BITS'($urandom);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_rows[r])
         send_op(probe_rows[r].mode, probe_rows[r].key, probe_rows[r].typed,
                 probe_rows[r].answer, probe_rows[r].status);

      n = 0;
      while (n < RANDOM_ITEMS) begin
         sender_calm = (n >= 300 && n < 450);
         roll = $urandom_range(99);
         have_live = (live_keys.size() != 0);
         pick = have_live ? live_keys[$urandom_range(live_keys.size() - 1)] : fresh_key();
         if (roll < 38)
            send_op(MODE_INSERT, ($urandom_range(4) == 0) ? pick : fresh_key(),
                    1'b0, '0, STAT_OK);
         else if (roll < 58)
            send_op(MODE_DELETE, pick, 1'b0, '0, STAT_OK);
         else if (roll < 65)
            send_op(MODE_DELETE, pick ^ (KEY_BITS'(1) << $urandom_range(KEY_BITS - 1)),
                    1'b0, '0, STAT_OK);
         else if (roll < 97)
            send_op(MODE_QUERY,
                    $urandom_range(1) ? fresh_key() : pick ^ KEY_BITS'($urandom_range(15)),
                    1'b0, '0, STAT_OK);
         else
            send_op(MODE_IGNORED, fresh_key(), 1'b0, '0, STAT_OK);
         if (roll < 97)
            n++;
      end
      sender_calm = 1'b0;

      // A deleted key comes back on the idle nodes that its delete left behind.
      repeat (25) begin
         pick = live_keys[$urandom_range(live_keys.size() - 1)];
         send_op(MODE_DELETE, pick, 1'b0, '0, STAT_OK);
         send_op(MODE_INSERT, pick, 1'b0, '0, STAT_OK);
         send_op(MODE_QUERY, fresh_key(), 1'b0, '0, STAT_OK);
         send_op(MODE_INSERT, fresh_key(), 1'b0, '0, STAT_OK);
      end
      req_tvalid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d transfers: %0d inserts stored, %0d refused, %0d deletes, %0d absent,",
               items_sent, n_stored, n_full, n_removed, n_absent);
      $display("%0d queries, %0d ignored; %0d of %0d nodes in use, %0d mismatches.",
               n_queries, n_ignored, trie_next_free, NODES, mismatches);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("Timed out with %0d responses outstanding.", pending_outcomes.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

/* filelist.f */
hdl/btmx_pkg.sv
hdl/btmx_ram.sv
hdl/btmx_ctrl.sv
hdl/btmx_dpath.sv
hdl/binary_trie_max_xor.sv
hdl/btmx_checker.sv
tb/binary_trie_max_xor_tb.sv
